FILE: src/csbc_pkg.sv
`timescale 1ns / 1ps

package csbc_pkg;

  localparam logic [31:0] SEC_MIN  = 32'd60;
  localparam logic [31:0] SEC_HOUR = 32'd3600;
  localparam logic [31:0] SEC_DAY  = 32'd86400;
  localparam logic [31:0] SEC_YEAR = 32'd31536000;

  localparam logic REG_EPOCH = 1'b0;
  localparam logic REG_BASE  = 1'b1;

  localparam logic CMD_TO_SECONDS = 1'b0;
  localparam logic CMD_TO_FIELDS  = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEC,
    OP_MOD,
    OP_YEAR,
    OP_MONTH,
    OP_DIV,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    UNIT_DAY,
    UNIT_HOUR,
    UNIT_MIN
  } unit_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] step;
    unit_e      unit;
    logic       to_fields;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } stat_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return 8'(hi * 8'd10) + lo;
  endfunction

  function automatic logic [7:0] bcd_enc(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - (7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [8:0] cum_days(input logic [7:0] mo);
    logic [8:0] r;
    case (mo)
      8'd0, 8'd1: r = 9'd0;
      8'd2:       r = 9'd31;
      8'd3:       r = 9'd60;
      8'd4:       r = 9'd91;
      8'd5:       r = 9'd121;
      8'd6:       r = 9'd152;
      8'd7:       r = 9'd182;
      8'd8:       r = 9'd213;
      8'd9:       r = 9'd244;
      8'd10:      r = 9'd274;
      8'd11:      r = 9'd305;
      8'd12:      r = 9'd335;
      default:    r = 9'd366;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] month_sec(input logic [3:0] mon);
    logic [31:0] r;
    case (mon)
      4'd1:                         r = 32'd2505600;
      4'd3, 4'd5, 4'd8, 4'd10:      r = 32'd2592000;
      default:                      r = 32'd2678400;
    endcase
    return r;
  endfunction

endpackage

FILE: src/csbc_ctrl.sv
`timescale 1ns / 1ps

module csbc_ctrl
  import csbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_cmd_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_MOD,
    S_YEAR,
    S_MONTH,
    S_DIV,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [2:0] step_q;
  unit_e      unit_q;
  logic       cmd_q;
  logic       out_valid_q;
  logic       load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load_out    = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.step      = step_q;
    cmd_o.unit      = unit_q;
    cmd_o.to_fields = cmd_q;
    case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DEC:    cmd_o.op = OP_DEC;
      S_MOD:    cmd_o.op = OP_MOD;
      S_YEAR:   cmd_o.op = OP_YEAR;
      S_MONTH:  cmd_o.op = OP_MONTH;
      S_DIV:    cmd_o.op = OP_DIV;
      S_FINISH: cmd_o.op = load_out ? OP_FINISH : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      unit_q      <= UNIT_DAY;
      cmd_q       <= CMD_TO_SECONDS;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q <= in_cmd_i;
            if (in_cmd_i == CMD_TO_FIELDS) begin
              step_q  <= 3'd5;
              state_q <= S_MOD;
            end else begin
              step_q  <= 3'd0;
              state_q <= S_DEC;
            end
          end
        end
        S_DEC: begin
          if (step_q == 3'd3) begin
            state_q <= S_FINISH;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_MOD: begin
          if (step_q == 3'd0) begin
            state_q <= S_YEAR;
          end else begin
            step_q <= step_q - 3'd1;
          end
        end
        S_YEAR: begin
          if (stat_i.year_done) begin
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (stat_i.month_done) begin
            unit_q  <= UNIT_DAY;
            step_q  <= 3'd4;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_q == 3'd0) begin
            case (unit_q)
              UNIT_DAY: begin
                unit_q <= UNIT_HOUR;
                step_q <= 3'd4;
              end
              UNIT_HOUR: begin
                unit_q <= UNIT_MIN;
                step_q <= 3'd5;
              end
              default: begin
                state_q <= S_FINISH;
              end
            endcase
          end else begin
            step_q <= step_q - 3'd1;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/csbc_datapath.sv
`timescale 1ns / 1ps

module csbc_datapath
  import csbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic [71:0] in_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [79:0] out_data_o,
  output logic        out_err_o
);

  logic [30:0] epoch_q;
  logic [13:0] base_q;

  logic [31:0] acc_q;
  logic [13:0] y_q;
  logic [3:0]  mon_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [6:0]  sec_raw_q;
  logic [6:0]  min_raw_q;
  logic [5:0]  hour_raw_q;
  logic [5:0]  day_raw_q;
  logic [4:0]  mon_raw_q;
  logic [79:0] out_data_q;
  logic        out_err_q;

  logic [7:0]  s_dec;
  logic [7:0]  m_dec;
  logic [7:0]  h_dec;
  logic [7:0]  d_dec;
  logic [7:0]  mo_dec;
  logic [9:0]  days;
  logic [31:0] days_ext;
  logic [31:0] day_term;
  logic        leap;
  logic [31:0] year_len;
  logic [31:0] mon_len;
  logic [13:0] mod_sub;
  logic [31:0] divisor;
  logic [31:0] div_cmp;
  logic        div_hit;
  logic [13:0] y_mod;
  logic [6:0]  yr2;
  logic [4:0]  day_one;
  logic [3:0]  mon_one;

  assign s_dec    = bcd_dec({1'b0, sec_raw_q});
  assign m_dec    = bcd_dec({1'b0, min_raw_q});
  assign h_dec    = bcd_dec({2'b0, hour_raw_q});
  assign d_dec    = bcd_dec({2'b0, day_raw_q});
  assign mo_dec   = bcd_dec({3'b0, mon_raw_q});
  assign days     = 10'(d_dec) + 10'(cum_days(mo_dec)) - 10'd1;
  assign days_ext = {{22{days[9]}}, days};
  assign day_term = days_ext * SEC_DAY;

  assign leap = (y_q[1:0] == 2'd0) && (y_q != 14'd100) && (y_q != 14'd200) &&
                (y_q != 14'd300);
  assign year_len = leap ? (SEC_YEAR + SEC_DAY) : SEC_YEAR;
  assign mon_len  = month_sec(mon_q);
  assign mod_sub  = 14'(14'd400 << cmd_i.step);

  always_comb begin
    case (cmd_i.unit)
      UNIT_DAY:  divisor = SEC_DAY;
      UNIT_HOUR: divisor = SEC_HOUR;
      default:   divisor = SEC_MIN;
    endcase
  end
  assign div_cmp = divisor << cmd_i.step;
  assign div_hit = (acc_q >= div_cmp);

  assign stat_o.year_done  = (acc_q < year_len);
  assign stat_o.month_done = (mon_q == 4'd11) || (acc_q < mon_len);

  always_comb begin
    if (y_q >= 14'd300) begin
      y_mod = y_q - 14'd300;
    end else if (y_q >= 14'd200) begin
      y_mod = y_q - 14'd200;
    end else if (y_q >= 14'd100) begin
      y_mod = y_q - 14'd100;
    end else begin
      y_mod = y_q;
    end
  end
  assign yr2     = y_mod[6:0];
  assign day_one = day_q + 5'd1;
  assign mon_one = mon_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      base_q  <= 14'd1970;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_EPOCH: epoch_q <= cfg_wdata_i;
        REG_BASE:  base_q  <= cfg_wdata_i[13:0];
        default:   epoch_q <= epoch_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        acc_q      <= {1'b0, in_data_i[30:0]};
        sec_raw_q  <= in_data_i[37:31];
        min_raw_q  <= in_data_i[45:39];
        hour_raw_q <= in_data_i[52:47];
        day_raw_q  <= in_data_i[60:55];
        mon_raw_q  <= in_data_i[67:63];
        y_q        <= base_q;
        mon_q      <= '0;
        day_q      <= '0;
        hour_q     <= '0;
        min_q      <= '0;
      end
      OP_DEC: begin
        case (cmd_i.step)
          3'd0:    acc_q <= 32'(s_dec) + 32'(m_dec) * SEC_MIN;
          3'd1:    acc_q <= acc_q + 32'(h_dec) * SEC_HOUR;
          3'd2:    acc_q <= acc_q + day_term;
          default: acc_q <= acc_q + {1'b0, epoch_q};
        endcase
      end
      OP_MOD: begin
        if (y_q >= mod_sub) begin
          y_q <= y_q - mod_sub;
        end
      end
      OP_YEAR: begin
        if (!stat_o.year_done) begin
          acc_q <= acc_q - year_len;
          y_q   <= (y_q == 14'd399) ? 14'd0 : y_q + 14'd1;
        end
      end
      OP_MONTH: begin
        if (!stat_o.month_done) begin
          acc_q <= acc_q - mon_len;
          mon_q <= mon_q + 4'd1;
        end
      end
      OP_DIV: begin
        if (div_hit) begin
          acc_q <= acc_q - div_cmp;
          case (cmd_i.unit)
            UNIT_DAY:  day_q  <= day_q | 5'(5'd1 << cmd_i.step);
            UNIT_HOUR: hour_q <= hour_q | 5'(5'd1 << cmd_i.step);
            default:   min_q  <= min_q | 6'(6'd1 << cmd_i.step);
          endcase
        end
      end
      OP_FINISH: begin
        if (cmd_i.to_fields == CMD_TO_FIELDS) begin
          out_data_q <= {bcd_enc(yr2), bcd_enc({3'b0, mon_one}),
                         bcd_enc({2'b0, day_one}), bcd_enc({2'b0, hour_q}),
                         bcd_enc({1'b0, min_q}), bcd_enc(acc_q[6:0]), 32'd0};
          out_err_q  <= 1'b0;
        end else begin
          out_data_q <= {48'd0, acc_q};
          out_err_q  <= (d_dec == 8'd0) || (mo_dec == 8'd0) || (mo_dec > 8'd12);
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign out_data_o = out_data_q;
  assign out_err_o  = out_err_q;

endmodule

FILE: src/calendar_seconds_bcd_converter_unit.sv
// Seconds to and from BCD calendar fields, one word in flight at a time.
// Fields to seconds: decode steps add seconds and minutes, hours, days, then epoch_offset.
// Seconds to fields: run time depends on the years and months; it is set by the
// one-year-per-cycle subtract loop and a shared restoring divider stage.
// A new word is taken while the previous result still waits at the output.
// Reset (async, active low) clears control, epoch_offset to 0, base_year to 1970.
`timescale 1ns / 1ps

module calendar_seconds_bcd_converter_unit
  import csbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // seconds_in[30:0], sec_bcd_in, min_bcd_in, hour_bcd_in, day_bcd_in, month_bcd_in, pad
  input  logic [71:0] s_axis_tdata_i,
  // command
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // seconds_out[31:0], sec, min, hour, day, month, year BCD bytes
  output logic [79:0] m_axis_tdata_o,
  // range_error
  output logic        m_axis_tuser_o
);

  cmd_t  cmd;
  stat_t stat;

  csbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  csbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule
